[rtl/core/bmh_pkg.sv]
// ----------------------------------------------------------------------------
// bmh_pkg
// shared types and constants of the bounded max-heap core
// ----------------------------------------------------------------------------
`default_nettype none

package bmh_pkg;

  // heap geometry and word widths
  localparam int MAX_ENTRIES = 64;
  localparam int KEY_BITS    = 32;
  localparam int VERTEX_BITS = 20;
  localparam int CMD_BITS    = 2;
  localparam int CAP_W       = 7;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // capacity after reset, and the entry count it gives
  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64);
  localparam logic [CNT_W-1:0] COUNT_RESET    =
    CNT_W'((MAX_ENTRIES < 64) ? MAX_ENTRIES : 64);

  // command codes
  typedef enum logic [CMD_BITS-1:0] {
    CMD_RESTART = 2'd0,
    CMD_FILL    = 2'd1,
    CMD_REPLACE = 2'd2,
    CMD_POP     = 2'd3
  } cmd_t;

  // one stored heap entry
  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [VERTEX_BITS-1:0] vertex;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // empty slot: maximum key, vertex zero
  localparam entry_t EMPTY_ENTRY = '{key: '1, vertex: '0};

  // input word
  typedef struct packed {
    cmd_t                   command;
    logic [KEY_BITS-1:0]    distance;
    logic [VERTEX_BITS-1:0] vertex;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [VERTEX_BITS-1:0] top_vertex;
    logic [KEY_BITS-1:0]    top_distance;
    logic [CNT_W-1:0]       entry_count;
    logic                   error;
  } out_word_t;

endpackage

`default_nettype wire

[rtl/core/bmh_ram.sv]
// ----------------------------------------------------------------------------
// bmh_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[rtl/core/bounded_max_heap_replace_top_core.sv]
// ----------------------------------------------------------------------------
// bounded_max_heap_replace_top_core
// bounded binary max-heap of (distance, vertex) pairs for k-nearest selection
// ----------------------------------------------------------------------------
// One command word at a time. For restart and fill, every slot is
// marked empty at once through a per-entry valid bit, so there is no clearing
// pass after reset. Replace and pop walk the sift-down loop against a
// two-read-port entry memory: each level descended is a child read, then a
// compare and write-back, and pop first fetches the last entry. A finished
// result sits in an output register, so the next word is taken while it waits.
`default_nettype none

module bounded_max_heap_replace_top_core
  import bmh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // command words
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_word_t         in_data,
  // result words
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_data,
  // capacity register
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_POP_RD   = 6'b000010,
    S_POP_LD   = 6'b000100,
    S_SIFT_RD  = 6'b001000,
    S_SIFT_CMP = 6'b010000,
    S_FIN      = 6'b100000
  } state_t;

  state_t                 state;
  logic [CAP_W-1:0]       capacity;
  logic [CNT_W-1:0]       count;
  logic [MAX_ENTRIES-1:0] valid;
  entry_t                 top;
  entry_t                 carry;
  logic [IDX_W-1:0]       at;
  logic                   err_flag;
  logic                   rv_a;
  logic                   rv_b;

  logic                   in_take;
  logic                   out_free;
  logic [CNT_W-1:0]       cap_limit;
  logic [CNT_W:0]         lc;
  logic [CNT_W:0]         rc;
  logic                   lc_ok;
  logic                   rc_ok;
  logic [IDX_W-1:0]       pop_addr;
  logic [IDX_W-1:0]       raddr_a;
  logic [IDX_W-1:0]       raddr_b;
  logic [ENTRY_W-1:0]     rdata_a;
  logic [ENTRY_W-1:0]     rdata_b;
  entry_t                 child_a;
  entry_t                 child_b;
  logic                   take_l;
  logic                   take_r;
  logic [KEY_BITS-1:0]    best_key;
  logic                   moved;
  logic                   we;
  entry_t                 wdata;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // restart count, limited to the slots present
  assign cap_limit = (32'(capacity) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                       : CNT_W'(capacity);

  // child indexes of the current slot
  assign lc    = (CNT_W + 1)'({at, 1'b0}) + (CNT_W + 1)'(1);
  assign rc    = lc + (CNT_W + 1)'(1);
  assign lc_ok = lc < (CNT_W + 1)'(count);
  assign rc_ok = rc < (CNT_W + 1)'(count);

  // read addresses: last entry for pop, else both children
  assign pop_addr = IDX_W'(count - CNT_W'(1));
  assign raddr_a  = (state == S_POP_RD) ? pop_addr : lc[IDX_W-1:0];
  assign raddr_b  = rc[IDX_W-1:0];

  // entries never written since restart or fill read as empty
  assign child_a = rv_a ? entry_t'(rdata_a) : EMPTY_ENTRY;
  assign child_b = rv_b ? entry_t'(rdata_b) : EMPTY_ENTRY;

  // sift-down compare, left child tested first, strict greater wins
  assign take_l   = lc_ok && (child_a.key > carry.key);
  assign best_key = take_l ? child_a.key : carry.key;
  assign take_r   = rc_ok && (child_b.key > best_key);
  assign moved    = (state == S_SIFT_CMP) && (take_l || take_r);

  // write-back at the current slot
  always_comb begin
    we    = ((state == S_SIFT_RD) && !lc_ok) || (state == S_SIFT_CMP);
    wdata = carry;
    if (moved) begin
      wdata = take_r ? child_b : child_a;
    end
  end

  bmh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (at),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= CAPACITY_RESET;
      count     <= COUNT_RESET;
      valid     <= '0;
      top       <= EMPTY_ENTRY;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      // result word handshake
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (we) begin
        valid[at] <= 1'b1;
        if (at == '0) begin
          top <= wdata;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            case (in_data.command)
              CMD_RESTART: begin
                valid <= '0;
                count <= cap_limit;
                top   <= EMPTY_ENTRY;
                state <= S_FIN;
              end
              CMD_FILL: begin
                valid <= '0;
                top   <= EMPTY_ENTRY;
                state <= S_FIN;
              end
              CMD_REPLACE: begin
                state <= (count == '0) ? S_FIN : S_SIFT_RD;
              end
              CMD_POP: begin
                state <= (count == '0) ? S_FIN : S_POP_RD;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_POP_RD: begin
          state <= S_POP_LD;
        end
        S_POP_LD: begin
          count <= count - CNT_W'(1);
          state <= S_SIFT_RD;
        end
        S_SIFT_RD: begin
          state <= lc_ok ? S_SIFT_CMP : S_FIN;
        end
        S_SIFT_CMP: begin
          state <= moved ? S_SIFT_RD : S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rv_a <= valid[raddr_a];
    rv_b <= valid[raddr_b];
    if (in_take) begin
      err_flag <= ((in_data.command == CMD_REPLACE) || (in_data.command == CMD_POP))
                  && (count == '0);
      carry    <= '{key: in_data.distance, vertex: in_data.vertex};
      at       <= '0;
    end
    if (state == S_POP_LD) begin
      carry <= child_a;
      at    <= '0;
    end
    if (moved) begin
      at <= take_r ? rc[IDX_W-1:0] : lc[IDX_W-1:0];
    end
    if ((state == S_FIN) && out_free) begin
      out_data.top_vertex   <= (count == '0) ? '0 : top.vertex;
      out_data.top_distance <= (count == '0) ? '0 : top.key;
      out_data.entry_count  <= count;
      out_data.error        <= err_flag;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bmh_checker.sv]
// ----------------------------------------------------------------------------
// bmh_checker
// port-level checks on the result words of the max-heap core
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_checker
  import bmh_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // count never exceeds the slots present
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data.entry_count) <= 32'(MAX_ENTRIES))
    else $error("entry count beyond heap size");

  // an empty heap shows a zero top
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.entry_count == '0) |->
      (out_data.top_distance == '0) && (out_data.top_vertex == '0))
    else $error("empty heap with non-zero top");

  // the error flag is only raised on an empty heap
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error |-> out_data.entry_count == '0)
    else $error("error flag with entries held");

endmodule

bind bounded_max_heap_replace_top_core bmh_checker u_bmh_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
